### rtl/pswt_pkg.sv
// Shared types, sizes and saturating adders for the priority wait-time scheduler.
// No dependencies; every rtl file imports this package.
package pswt_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam logic [19:0] MAX20 = 20'hF_FFFF;
    localparam logic [23:0] MAX24 = 24'hFF_FFFF;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [7:0]  id;
    } rec_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        rec_t             wdata;
        logic [IDX_W-1:0] raddr;
    } tbl_req_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RDI,
        ST_LATCH,
        ST_CMP,
        ST_WRI,
        ST_EMIT_RD,
        ST_EMIT_TAT,
        ST_EMIT_OUT
    } state_t;

    function automatic logic [19:0] sat_add20(input logic [19:0] a, input logic [15:0] b);
        logic [20:0] s;
        s = {1'b0, a} + {5'd0, b};
        return s[20] ? MAX20 : s[19:0];
    endfunction

    function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [19:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {5'd0, b};
        return s[24] ? MAX24 : s[23:0];
    endfunction

endpackage

### rtl/pswt_table.sv
// Process table: one write port, one read port with registered read data.
// Depends on pswt_pkg.
module pswt_table (
    input  logic               clk,
    input  pswt_pkg::tbl_req_t req,
    output pswt_pkg::rec_t     rdata
);
    import pswt_pkg::*;

    rec_t mem [MAX_PROCS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

### rtl/priority_schedule_wait_times_core.sv
// Priority scheduler top level: loads a batch, exchange-sorts it by priority, reports times.
// Load: one word per cycle. After the closing word (last_in, or table full with N words)
// the core sorts the batch, with the compare loop running over the table read port,
// then reads and emits each result in turn. Input is stalled meanwhile.
// Reset (async, rst_n low) empties the batch, clears sums and the output valid.
module priority_schedule_wait_times_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  proc_id,
    input  logic [15:0] burst,
    input  logic [7:0]  prio,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_id,
    output logic [15:0] out_burst,
    output logic [7:0]  out_prio,
    output logic [19:0] wait_time,
    output logic [19:0] turnaround,
    output logic [23:0] total_wait,
    output logic [23:0] total_turnaround,
    output logic        last_out
);
    import pswt_pkg::*;

    // Sequencer state and loop counters.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;     // words loaded so far
    logic [CNT_W-1:0] n_reg, n_next;         // batch size once closed
    logic [IDX_W-1:0] i_reg, i_next;         // sort position being settled
    logic [IDX_W-1:0] j_reg, j_next;         // scan position
    logic [IDX_W-1:0] k_reg, k_next;         // emit position

    // Sort and emit datapath.
    rec_t             cur_reg, cur_next;     // running holder of table[i]
    rec_t             rec_reg, rec_next;     // record being emitted
    logic [19:0]      elapsed_reg, elapsed_next;
    logic [19:0]      wait_reg, wait_next;   // wait of record being emitted
    logic [19:0]      tat_reg, tat_next;
    logic [23:0]      wsum_reg, wsum_next;
    logic [23:0]      tsum_reg, tsum_next;

    // Output register.
    logic             ovalid_reg, ovalid_next;
    logic [7:0]       oid_reg, oid_next;
    logic [15:0]      oburst_reg, oburst_next;
    logic [7:0]       oprio_reg, oprio_next;
    logic [19:0]      owait_reg, owait_next;
    logic [19:0]      otat_reg, otat_next;
    logic [23:0]      otw_reg, otw_next;
    logic [23:0]      ott_reg, ott_next;
    logic             olast_reg, olast_next;

    tbl_req_t         tbl_req;
    rec_t             tbl_rdata;

    logic             in_take;
    logic             load_close;
    logic             scan_end;
    logic             sort_end;
    logic             emit_end;
    logic             slot_free;
    logic             swap;

    pswt_table u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    // Status decodes shared by the next-state and datapath blocks.
    assign in_take    = (state_reg == ST_LOAD) && in_valid;
    assign load_close = last_in || (cnt_reg + CNT_W'(1) == CNT_W'(MAX_PROCS));
    assign scan_end   = (CNT_W'(j_reg) == n_reg - CNT_W'(1));
    assign sort_end   = (CNT_W'(i_reg) + CNT_W'(2) == n_reg);
    assign emit_end   = (CNT_W'(k_reg) == n_reg - CNT_W'(1));
    assign slot_free  = !ovalid_reg || !out_stall;
    // The single comparator: swap when the held entry has a larger priority value than the scanned one.
    assign swap       = cur_reg.prio > tbl_rdata.prio;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_take && load_close)
                begin
                    // A single-word batch is already sorted.
                    state_next = (cnt_reg == '0) ? ST_EMIT_RD : ST_RDI;
                end
            end
            ST_RDI:      state_next = ST_LATCH;
            ST_LATCH:    state_next = ST_CMP;
            ST_CMP:      state_next = scan_end ? ST_WRI : ST_CMP;
            ST_WRI:      state_next = sort_end ? ST_EMIT_RD : ST_RDI;
            ST_EMIT_RD:  state_next = ST_EMIT_TAT;
            ST_EMIT_TAT: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (slot_free)
                begin
                    state_next = emit_end ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // Table port control.
    always_comb
    begin
        tbl_req.we    = 1'b0;
        tbl_req.waddr = cnt_reg[IDX_W-1:0];
        tbl_req.wdata = '{prio: prio, burst: burst, id: proc_id};
        tbl_req.raddr = i_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                tbl_req.we = in_take;
            end
            ST_RDI:
            begin
                tbl_req.raddr = i_reg;
            end
            ST_LATCH:
            begin
                tbl_req.raddr = j_reg;
            end
            ST_CMP:
            begin
                // Drop the held entry into slot j on a swap; prefetch j+1.
                tbl_req.we    = swap;
                tbl_req.waddr = j_reg;
                tbl_req.wdata = cur_reg;
                tbl_req.raddr = j_reg + IDX_W'(1);
            end
            ST_WRI:
            begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = i_reg;
                tbl_req.wdata = cur_reg;
            end
            ST_EMIT_RD, ST_EMIT_TAT, ST_EMIT_OUT:
            begin
                tbl_req.raddr = k_reg;
            end
            default:
            begin
                tbl_req.we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        rec_next     = rec_reg;
        elapsed_next = elapsed_reg;
        wait_next    = wait_reg;
        tat_next     = tat_reg;
        wsum_next    = wsum_reg;
        tsum_next    = tsum_reg;
        ovalid_next  = ovalid_reg && out_stall;
        oid_next     = oid_reg;
        oburst_next  = oburst_reg;
        oprio_next   = oprio_reg;
        owait_next   = owait_reg;
        otat_next    = otat_reg;
        otw_next     = otw_reg;
        ott_next     = ott_reg;
        olast_next   = olast_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_take)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (load_close)
                    begin
                        n_next = cnt_reg + CNT_W'(1);
                        i_next = '0;
                        k_next = '0;
                    end
                end
            end
            ST_RDI:
            begin
                j_next = i_reg + IDX_W'(1);
            end
            ST_LATCH:
            begin
                cur_next = tbl_rdata;
            end
            ST_CMP:
            begin
                if (swap)
                begin
                    cur_next = tbl_rdata;
                end
                if (!scan_end)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_WRI:
            begin
                i_next = i_reg + IDX_W'(1);
            end
            ST_EMIT_RD:
            begin
                rec_next = rec_reg;
            end
            ST_EMIT_TAT:
            begin
                // Waiting time is what has elapsed; fold it into the wait total.
                rec_next  = tbl_rdata;
                wait_next = elapsed_reg;
                tat_next  = sat_add20(elapsed_reg, tbl_rdata.burst);
                wsum_next = sat_add24(wsum_reg, elapsed_reg);
            end
            ST_EMIT_OUT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oid_next    = rec_reg.id;
                    oburst_next = rec_reg.burst;
                    oprio_next  = rec_reg.prio;
                    owait_next  = wait_reg;
                    otat_next   = tat_reg;
                    olast_next  = emit_end;
                    otw_next    = emit_end ? wsum_reg : '0;
                    ott_next    = emit_end ? sat_add24(tsum_reg, tat_reg) : '0;
                    if (emit_end)
                    begin
                        // Batch done: empty the table and clear the sums.
                        cnt_next     = '0;
                        elapsed_next = '0;
                        wsum_next    = '0;
                        tsum_next    = '0;
                    end
                    else
                    begin
                        elapsed_next = tat_reg;
                        tsum_next    = sat_add24(tsum_reg, tat_reg);
                        k_next       = k_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
            wsum_reg    <= '0;
            tsum_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
            wsum_reg    <= wsum_next;
            tsum_reg    <= tsum_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        rec_reg    <= rec_next;
        wait_reg   <= wait_next;
        tat_reg    <= tat_next;
        oid_reg    <= oid_next;
        oburst_reg <= oburst_next;
        oprio_reg  <= oprio_next;
        owait_reg  <= owait_next;
        otat_reg   <= otat_next;
        otw_reg    <= otw_next;
        ott_reg    <= ott_next;
        olast_reg  <= olast_next;
    end

    // Hold the input off everywhere but the load phase.
    assign in_stall         = (state_reg != ST_LOAD);
    assign out_valid        = ovalid_reg;
    assign out_id           = oid_reg;
    assign out_burst        = oburst_reg;
    assign out_prio         = oprio_reg;
    assign wait_time        = owait_reg;
    assign turnaround       = otat_reg;
    assign total_wait       = otw_reg;
    assign total_turnaround = ott_reg;
    assign last_out         = olast_reg;

endmodule

### sim/priority_schedule_wait_times_core_tb.sv
// Self-checking bench for priority_schedule_wait_times_core: priority sort and wait-time report.
// Depends on rtl/pswt_pkg.sv (record type, table size, saturation limits) and the core itself.
`timescale 1ns / 100ps

module priority_schedule_wait_times_core_tb;
    import pswt_pkg::*;

    // One scheduled process as the core reports it.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [19:0] wait_tm;
        logic [19:0] tat;
        logic [23:0] tot_wait;
        logic [23:0] tot_tat;
        logic        fin;
    } sched_out_t;

    // Batch predictor and store of pending schedule entries.
    class sched_board;
        rec_t       batch[MAX_PROCS];
        int         fill;
        sched_out_t due[$];
        int         errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(string msg);
            // Keep the log short on a broken core; count every miss anyway.
            if (errors < 40)
                $display("%0t ns: MISMATCH %s", $time, msg);
            errors++;
        endtask

        // Note one accepted word; a closing word turns the batch into expected results.
        function void note_word(rec_t r, logic fin);
            rec_t        tmp;
            sched_out_t  o;
            int unsigned elapsed;
            int unsigned w_sum;
            int unsigned t_sum;
            int unsigned s;

            batch[fill] = r;
            fill++;
            if (!fin && fill < MAX_PROCS)
                return;

            // Exchange sort, strict compare: this exact pass order decides ties.
            for (int i = 0; i < fill - 1; i++)
                for (int j = i + 1; j < fill; j++)
                    if (batch[i].prio > batch[j].prio) begin
                        tmp      = batch[i];
                        batch[i] = batch[j];
                        batch[j] = tmp;
                    end

            elapsed = 0;
            w_sum   = 0;
            t_sum   = 0;
            for (int i = 0; i < fill; i++) begin
                s = elapsed + 32'(batch[i].burst);
                if (s > 32'(MAX20))
                    s = 32'(MAX20);
                w_sum += elapsed;
                if (w_sum > 32'(MAX24))
                    w_sum = 32'(MAX24);
                t_sum += s;
                if (t_sum > 32'(MAX24))
                    t_sum = 32'(MAX24);
                o.id       = batch[i].id;
                o.burst    = batch[i].burst;
                o.prio     = batch[i].prio;
                o.wait_tm  = elapsed[19:0];
                o.tat      = s[19:0];
                o.fin      = (i == fill - 1);
                o.tot_wait = o.fin ? w_sum[23:0] : 24'd0;
                o.tot_tat  = o.fin ? t_sum[23:0] : 24'd0;
                due.push_back(o);
                elapsed = s;
            end
            fill = 0;
        endfunction

        task field_chk(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        // Compare one accepted result word with the oldest pending entry.
        task check_result(sched_out_t got);
            sched_out_t want;

            if (due.size() == 0) begin
                report($sformatf("unexpected result id %0d", got.id));
                return;
            end
            want = due.pop_front();
            field_chk("out_id", 32'(got.id), 32'(want.id));
            field_chk("out_burst", 32'(got.burst), 32'(want.burst));
            field_chk("out_prio", 32'(got.prio), 32'(want.prio));
            field_chk("wait_time", 32'(got.wait_tm), 32'(want.wait_tm));
            field_chk("turnaround", 32'(got.tat), 32'(want.tat));
            field_chk("total_wait", 32'(got.tot_wait), 32'(want.tot_wait));
            field_chk("total_turnaround", 32'(got.tot_tat), 32'(want.tot_tat));
            field_chk("last_out", 32'(got.fin), 32'(want.fin));
        endtask
    endclass

    // Clock, reset and every core input start at a known value.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  proc_id   = 8'd0;
    logic [15:0] burst     = 16'd0;
    logic [7:0]  prio      = 8'd0;
    logic        last_in   = 1'b0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_id;
    logic [15:0] out_burst;
    logic [7:0]  out_prio;
    logic [19:0] wait_time;
    logic [19:0] turnaround;
    logic [23:0] total_wait;
    logic [23:0] total_turnaround;
    logic        last_out;

    // Shared between the feeder and the result taker.
    bit calm     = 1'b0;   // suppress random idling on both sides
    bit hold_req = 1'b0;   // ask the result taker for one long hold-off

    sched_board book = new();

    priority_schedule_wait_times_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .proc_id          (proc_id),
        .burst            (burst),
        .prio             (prio),
        .last_in          (last_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_id           (out_id),
        .out_burst        (out_burst),
        .out_prio         (out_prio),
        .wait_time        (wait_time),
        .turnaround       (turnaround),
        .total_wait       (total_wait),
        .total_turnaround (total_turnaround),
        .last_out         (last_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one process word and hold it until the core takes it. Inputs change
    // only at a rising edge; handshake signals are sampled there before they update.
    task automatic send_word(input logic [7:0] id, input logic [15:0] b,
                             input logic [7:0] p, input logic fin);
        rec_t r;

        // Insert random idle cycles ahead of the word, except in the calm stretch.
        while (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        proc_id  <= id;
        burst    <= b;
        prio     <= p;
        last_in  <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r.prio  = p;
        r.burst = b;
        r.id    = id;
        book.note_word(r, fin);
    endtask

    // Drop valid and wait for the core to deliver everything it owes.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.due.size() != 0)
            @(posedge clk);
    endtask

    // Result taker: check each accepted word, then pick the next stall value.
    // The long hold-off is counted here so the feeder keeps pushing meanwhile.
    initial
    begin
        int  hold_left;
        bit  hold_taken;

        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                book.check_result('{out_id, out_burst, out_prio, wait_time, turnaround,
                                    total_wait, total_turnaround, last_out});
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 300;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 16);
        end
    end

    // Main sequence: reset, directed batches, random batches, drain and verdict.
    initial
    begin
        int   sent;
        int   size;
        bit   ties;
        bit   paused;
        logic fin;
        logic [15:0] b;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-process batch: all fields at zero.
        send_word(8'd0, 16'd0, 8'd0, 1'b1);
        // Two processes at the field maxima and minima; the later one sorts first.
        send_word(8'd255, 16'hFFFF, 8'd255, 1'b0);
        send_word(8'd0, 16'd0, 8'd0, 1'b1);
        // Equal priorities: the exchange pattern decides the final order.
        send_word(8'd10, 16'd100, 8'd7, 1'b0);
        send_word(8'd11, 16'd200, 8'd7, 1'b0);
        send_word(8'd12, 16'd300, 8'd3, 1'b1);
        // Full table with no closing flag: the sixteenth word closes the batch.
        // Maximum bursts push the running sums to their largest reachable values.
        for (int k = 0; k < MAX_PROCS; k++)
            send_word(8'(240 + k), 16'hFFFF, 8'(15 - k / 2), 1'b0);

        sent   = 0;
        paused = 1'b0;
        while (sent < 400)
        begin
            size = $urandom_range(MAX_PROCS, 1);
            ties = 1'($urandom_range(1));
            // Block the result side for a long stretch while words keep coming.
            if (!hold_req && sent >= 100)
                hold_req = 1'b1;
            // Let the core run dry once before continuing.
            if (!paused && sent >= 300)
            begin
                paused = 1'b1;
                drain_results();
            end
            calm = (sent >= 160 && sent < 260);
            for (int k = 0; k < size; k++)
            begin
                fin = (k == size - 1);
                // A full batch closes on its own; the flag there is free.
                if (size == MAX_PROCS && k == MAX_PROCS - 1)
                    fin = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0:       b = 16'd0;
                    1:       b = 16'hFFFF;
                    default: b = 16'($urandom);
                endcase
                send_word(8'($urandom), b,
                          ties ? 8'($urandom_range(3)) : 8'($urandom), fin);
                sent++;
            end
        end

        // Wait for the last batch, then linger past a full sort to catch strays.
        drain_results();
        repeat (300) @(posedge clk);

        if (book.due.size() != 0)
            book.report($sformatf("%0d results never arrived", book.due.size()));
        if (book.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of these batches.
    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### priority_schedule_wait_times_core.f
rtl/pswt_pkg.sv
rtl/pswt_table.sv
rtl/priority_schedule_wait_times_core.sv
sim/priority_schedule_wait_times_core_tb.sv
